### hdl/ihre_pkg.sv
package ihre_pkg;

  // hand-off between neighboring cells of the byte row
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } ihre_link_t;

  localparam logic [6:0]  CHAR_COLON    = 7'h3A;
  localparam logic [6:0]  CHAR_NEWLINE  = 7'h0A;
  localparam logic [7:0]  REC_TYPE_DATA = 8'h00;
  localparam logic [7:0]  REC_TYPE_EOF  = 8'h01;
  localparam logic [7:0]  REC_TYPE_EXT  = 8'h04;
  localparam logic [7:0]  EXT_LEN       = 8'h02;
  localparam logic [15:0] UPPER_RESET   = 16'hFFFF;

  // upper-case hex digit as ascii
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] code;
    if (nib < 4'd10) begin
      code = 7'h30 + {3'b000, nib};
    end else begin
      code = 7'h37 + {3'b000, nib};
    end
    return code;
  endfunction

endpackage

### hdl/ihre_cell.sv
module ihre_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ihre_pkg::ihre_link_t up_i,
  input  logic                drain_i,
  output ihre_pkg::ihre_link_t cell_o
);
  import ihre_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       take;
  logic       leave;

  // take from the upper neighbor when empty, hand down when the lower one is empty
  assign take  = up_i.valid & ~valid_q;
  assign leave = valid_q & drain_i;

  always_comb begin
    valid_d = take | (valid_q & ~leave);
    data_d  = take ? up_i.data : data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.data  = data_q;

endmodule

### hdl/intel_hex_record_encoder_unit.sv
// Intel HEX encoder: takes image bytes on the slave stream (tlast marks the final byte of an
// image) and sends the hex text as one ascii character per request on the master stream, with
// tlast on the last character caused by each byte. Image bytes enter the top cell of a row of
// RECORD_BYTES cells and walk down one cell per cycle while the cell below is empty; the
// character sequencer reads them from the bottom cell. A byte that only joins the open record
// produces no text, and the next byte is taken once the top cell has emptied. A byte that
// produces text holds the input until its last character is sent: 16 characters for an
// address record and 12 for the end record. A data record of n bytes has 12 + 2*n characters,
// and the sequencer waits while the bottom cell refills after each byte is read; when no
// address record comes before it, it also waits for the byte just taken to walk down the row.
// Output stalls hold the sequencer as well.
// The output register lets the next byte be taken while the last character still waits.
module intel_hex_record_encoder_unit #(
  parameter int RECORD_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: base address of the first image byte
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // output characters
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero
  output logic        m_axis_tlast    // end_of_run
);
  import ihre_pkg::*;

  localparam int FILL_W = $clog2(RECORD_BYTES + 1);
  localparam int CNT_W  = (RECORD_BYTES < 2) ? 2 : FILL_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COLON = 6'b000010,
    S_HEAD  = 6'b000100,
    S_BODY  = 6'b001000,
    S_CKSUM = 6'b010000,
    S_NL    = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    REC_EXT,
    REC_DATA,
    REC_EOF
  } rec_e;

  state_e              state_q, state_d;
  rec_e                kind_q, kind_d;
  logic                pend_data_q, pend_data_d;
  logic                pend_eof_q, pend_eof_d;
  logic [31:0]         base_q, base_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [31:0]         offset_q, offset_d;
  logic [15:0]         upper_q, upper_d;
  logic [31:0]         hdr_q, hdr_d;
  logic [15:0]         ext_q, ext_d;
  logic [31:0]         data_hdr_q, data_hdr_d;
  logic [CNT_W-1:0]    data_len_q, data_len_d;
  logic [CNT_W-1:0]    bcnt_q, bcnt_d;
  logic [1:0]          hcnt_q, hcnt_d;
  logic                nib_q, nib_d;
  logic [7:0]          acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  logic [6:0]          out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  ihre_link_t          row [RECORD_BYTES];
  ihre_link_t          entry;
  logic                row_pop;

  logic                in_acc;
  logic                out_free;
  logic                body_wait;
  logic                emit;
  logic [7:0]          cur_byte;
  logic [3:0]          cur_nib;
  logic [6:0]          cur_char;
  logic                cur_last;
  logic [FILL_W-1:0]   fill_n;
  logic [31:0]         rec_addr;
  logic [15:0]         start16;
  logic                do_ext;
  logic                do_data;
  logic                load;
  rec_e                load_kind;

  // row of byte cells, entry at the top, read at the bottom
  assign entry.valid = in_acc;
  assign entry.data  = s_axis_tdata;

  for (genvar i = 0; i < RECORD_BYTES; i++) begin : g_row
    ihre_link_t up;
    logic       drain;
    if (i == RECORD_BYTES - 1) begin : g_top
      assign up = entry;
    end else begin : g_mid
      assign up = row[i+1];
    end
    if (i == 0) begin : g_bottom
      assign drain = row_pop;
    end else begin : g_upper
      assign drain = ~row[i-1].valid;
    end
    ihre_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .up_i   (up),
      .drain_i(drain),
      .cell_o (row[i])
    );
  end

  // handshakes
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) & ~row[RECORD_BYTES-1].valid;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign body_wait     = (state_q == S_BODY) & (kind_q == REC_DATA) & ~row[0].valid;
  assign emit          = (state_q != S_IDLE) & out_free & ~body_wait;
  assign row_pop       = emit & (state_q == S_BODY) & (kind_q == REC_DATA) & nib_q;

  // character selection
  always_comb begin
    unique case (state_q)
      S_HEAD:  cur_byte = hdr_q[31:24];
      S_BODY:  cur_byte = (kind_q == REC_EXT) ? ext_q[15:8] : row[0].data;
      S_CKSUM: cur_byte = 8'h00 - acc_q;
      default: cur_byte = 8'h00;
    endcase
    cur_nib = nib_q ? cur_byte[3:0] : cur_byte[7:4];
    unique case (state_q)
      S_COLON: cur_char = CHAR_COLON;
      S_NL:    cur_char = CHAR_NEWLINE;
      default: cur_char = hex_char(cur_nib);
    endcase
    cur_last = (state_q == S_NL) & ~pend_data_q & ~pend_eof_q;
  end

  // record planning for an accepted byte
  always_comb begin
    fill_n   = fill_q + FILL_W'(1);
    rec_addr = base_q + offset_q;
    start16  = base_q[15:0] + offset_q[15:0] - 16'(fill_q);
    do_ext   = (fill_q == '0) & ((rec_addr[31:16] != upper_q) | (offset_q == '0));
    do_data  = (fill_n == FILL_W'(RECORD_BYTES)) | s_axis_tlast;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    pend_data_d = pend_data_q;
    pend_eof_d  = pend_eof_q;
    base_d      = cfg_we_i ? cfg_wdata_i : base_q;
    fill_d      = fill_q;
    offset_d    = offset_q;
    upper_d     = upper_q;
    hdr_d       = hdr_q;
    ext_d       = ext_q;
    data_hdr_d  = data_hdr_q;
    data_len_d  = data_len_q;
    bcnt_d      = bcnt_q;
    hcnt_d      = hcnt_q;
    nib_d       = nib_q;
    acc_d       = acc_q;
    load        = 1'b0;
    load_kind   = REC_EOF;

    // new byte joins the open record
    if (in_acc) begin
      offset_d = offset_q + 32'd1;
      fill_d   = do_data ? '0 : fill_n;
      if (do_data) begin
        data_hdr_d = {8'(fill_n), start16, REC_TYPE_DATA};
        data_len_d = CNT_W'(fill_n);
      end
      if (do_ext) begin
        upper_d     = rec_addr[31:16];
        ext_d       = rec_addr[31:16];
        load        = 1'b1;
        load_kind   = REC_EXT;
        pend_data_d = do_data;
        pend_eof_d  = s_axis_tlast;
      end else if (do_data) begin
        load        = 1'b1;
        load_kind   = REC_DATA;
        pend_data_d = 1'b0;
        pend_eof_d  = s_axis_tlast;
      end
      if (s_axis_tlast) begin
        offset_d = '0;
        upper_d  = UPPER_RESET;
        fill_d   = '0;
      end
    end

    // one character per emitted request
    if (emit) begin
      unique case (state_q)
        S_COLON: begin
          state_d = S_HEAD;
        end
        S_HEAD: begin
          nib_d = ~nib_q;
          if (nib_q) begin
            acc_d = acc_q + hdr_q[31:24];
            hdr_d = {hdr_q[23:0], 8'h00};
            if (hcnt_q == 2'd0) begin
              state_d = (bcnt_q == '0) ? S_CKSUM : S_BODY;
            end else begin
              hcnt_d = hcnt_q - 2'd1;
            end
          end
        end
        S_BODY: begin
          nib_d = ~nib_q;
          if (nib_q) begin
            acc_d  = acc_q + cur_byte;
            ext_d  = {ext_q[7:0], 8'h00};
            bcnt_d = bcnt_q - CNT_W'(1);
            if (bcnt_q == CNT_W'(1)) begin
              state_d = S_CKSUM;
            end
          end
        end
        S_CKSUM: begin
          nib_d = ~nib_q;
          if (nib_q) begin
            state_d = S_NL;
          end
        end
        S_NL: begin
          if (pend_data_q) begin
            load        = 1'b1;
            load_kind   = REC_DATA;
            pend_data_d = 1'b0;
          end else if (pend_eof_q) begin
            load       = 1'b1;
            load_kind  = REC_EOF;
            pend_eof_d = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end

    // start a record
    if (load) begin
      state_d = S_COLON;
      kind_d  = load_kind;
      acc_d   = 8'h00;
      nib_d   = 1'b0;
      hcnt_d  = 2'd3;
      case (load_kind)
        REC_EXT: begin
          hdr_d  = {EXT_LEN, 16'h0000, REC_TYPE_EXT};
          bcnt_d = CNT_W'(2);
        end
        REC_DATA: begin
          hdr_d  = data_hdr_d;
          bcnt_d = data_len_d;
        end
        default: begin
          hdr_d  = {8'h00, 16'h0000, REC_TYPE_EOF};
          bcnt_d = '0;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_char_d  = cur_char;
      out_last_d  = cur_last;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= REC_EOF;
      pend_data_q <= 1'b0;
      pend_eof_q  <= 1'b0;
      base_q      <= '0;
      fill_q      <= '0;
      offset_q    <= '0;
      upper_q     <= UPPER_RESET;
      bcnt_q      <= '0;
      hcnt_q      <= '0;
      nib_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      pend_data_q <= pend_data_d;
      pend_eof_q  <= pend_eof_d;
      base_q      <= base_d;
      fill_q      <= fill_d;
      offset_q    <= offset_d;
      upper_q     <= upper_d;
      bcnt_q      <= bcnt_d;
      hcnt_q      <= hcnt_d;
      nib_q       <= nib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q      <= hdr_d;
    ext_q      <= ext_d;
    data_hdr_q <= data_hdr_d;
    data_len_q <= data_len_d;
    acc_q      <= acc_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  // the bottom cell is only read while it holds a byte
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_pop |-> row[0].valid)
    else $error("byte row read while empty");

  // a run only ends on a newline
  a_last_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[6:0] == CHAR_NEWLINE))
    else $error("end of run not on a newline");

  // the final byte of an image always starts text
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (state_q == S_COLON))
    else $error("final byte did not start a record");

  // nothing is left queued when the sequencer is idle
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!pend_data_q && !pend_eof_q))
    else $error("record pending while idle");
`endif

endmodule
